// ===== rtl/dpspm_pkg.sv =====
// Package for the dual power spectrum peak and mask block.
// Holds the fixed field widths, configuration register indexes, the result
// record and the sequencer states. No dependencies.
package dpspm_pkg;

   // Fixed widths of the configuration and result fields.
   localparam int LOG2_W     = 4;
   localparam int POWER_W    = 50;
   localparam int BIN_OUT_W  = 9;
   localparam int COUNT_W    = 10;
   localparam int INDEX_W    = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 50;
   // Wide enough for the block length at the largest log2_bins value.
   localparam int LEN_W      = 16;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_LOG2_BINS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_FLOOR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_ENABLE = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [LOG2_W-1:0]  LOG2_BINS_RST   = 4'd10;
   localparam logic [POWER_W-1:0] PEAK_FLOOR_RST  = '0;
   localparam logic               MASK_ENABLE_RST = 1'b1;

   // Input transaction kinds.
   localparam logic KIND_MASK = 1'b0;
   localparam logic KIND_BIN  = 1'b1;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_PASS,
      ST_DRAIN
   } state_type;

   // One result transaction.
   typedef struct packed {
      logic                 channel;
      logic                 peak_found;
      logic [BIN_OUT_W-1:0] peak_bin;
      logic [POWER_W-1:0]   peak_power;
      logic [COUNT_W-1:0]   violation_count;
      logic [BIN_OUT_W-1:0] first_bin;
      logic [POWER_W-1:0]   first_power;
      logic [BIN_OUT_W-1:0] last_bin;
      logic [POWER_W-1:0]   final_power;
      logic                 last;
   } rsp_type;

endpackage

// ===== rtl/dual_power_spectrum_peak_mask.sv =====
// Dual real-channel power spectrum, peak search and spectrum mask check.
// Results follow bin N-1 via the read, sum, square, power, accumulator and result registers.
// Throughput: one bin or mask transaction per cycle while loading; the tail pass then
// reads bin k and its mirror bin once per cycle from the bin store, taking no input meanwhile.
// Reset clears the sequencer, valid flags, result handshake flags and configuration registers;
// the bin and mask stores hold nothing defined until they are written.
module dual_power_spectrum_peak_mask #(
   parameter int MAX_BINS    = 1024,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Configuration write port
   input  logic                                  csr_we,
   input  logic [dpspm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dpspm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // Input channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic [dpspm_pkg::INDEX_W-1:0]         req_index,
   input  logic signed [SAMPLE_BITS-1:0]         req_real_part,
   input  logic signed [SAMPLE_BITS-1:0]         req_imag_part,
   input  logic [dpspm_pkg::POWER_W-1:0]         req_mask_level,
   // Result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_channel,
   output logic                                  rsp_peak_found,
   output logic [dpspm_pkg::BIN_OUT_W-1:0]       rsp_peak_bin,
   output logic [dpspm_pkg::POWER_W-1:0]         rsp_peak_power,
   output logic [dpspm_pkg::COUNT_W-1:0]         rsp_violation_count,
   output logic [dpspm_pkg::BIN_OUT_W-1:0]       rsp_first_bin,
   output logic [dpspm_pkg::POWER_W-1:0]         rsp_first_power,
   output logic [dpspm_pkg::BIN_OUT_W-1:0]       rsp_last_bin,
   output logic [dpspm_pkg::POWER_W-1:0]         rsp_final_power,
   output logic                                  rsp_last
);

   // Address widths of the two stores. The bin store holds MAX_BINS complex
   // bins, the mask store one threshold for each positive-frequency bin.
   localparam int LMAX  = $clog2(MAX_BINS + 1) - 1;
   localparam int AW    = LMAX;
   localparam int HALF  = MAX_BINS / 2;
   localparam int KW    = $clog2(HALF);
   localparam int CNTW  = $clog2(HALF + 1);
   // Sum and difference of two samples, their squares and the power.
   localparam int SW1   = SAMPLE_BITS + 1;
   localparam int PW    = 2 * SAMPLE_BITS + 2;
   localparam int OW    = dpspm_pkg::POWER_W;
   // Comparisons run at whichever is wider: the power or the 50-bit thresholds.
   localparam int CW    = (PW > OW) ? PW : OW;
   localparam int LW    = dpspm_pkg::LEN_W;
   localparam int BOW   = dpspm_pkg::BIN_OUT_W;
   localparam int COW   = dpspm_pkg::COUNT_W;

   // Running peak and mask statistics of one channel.
   typedef struct packed {
      logic            found;
      logic [KW-1:0]   best_bin;
      logic [CW-1:0]   best;
      logic [CNTW-1:0] count;
      logic [KW-1:0]   first_bin;
      logic [CW-1:0]   first_power;
      logic [KW-1:0]   last_bin;
      logic [CW-1:0]   last_power;
   } acc_type;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [dpspm_pkg::LOG2_W-1:0]  log2_bins_ff;
   logic [OW-1:0]                 peak_floor_ff;
   logic                          mask_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_bins_ff   <= dpspm_pkg::LOG2_BINS_RST;
         peak_floor_ff  <= dpspm_pkg::PEAK_FLOOR_RST;
         mask_enable_ff <= dpspm_pkg::MASK_ENABLE_RST;
      end else if (csr_we) begin
         // Writes to an index beyond the register list are dropped.
         unique case (csr_index)
            dpspm_pkg::CSR_LOG2_BINS:   log2_bins_ff <= csr_wdata[dpspm_pkg::LOG2_W-1:0];
            dpspm_pkg::CSR_PEAK_FLOOR:  peak_floor_ff <= csr_wdata[OW-1:0];
            dpspm_pkg::CSR_MASK_ENABLE: mask_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Block length in use: log2_bins is clamped to the range the store supports.
   logic [dpspm_pkg::LOG2_W-1:0] l_eff;
   logic [LW-1:0]                n_len;
   logic [LW-1:0]                n_m1;
   logic [KW-1:0]                half_m1;

   always_comb begin
      if (log2_bins_ff < 4'd2) begin
         l_eff = 4'd2;
      end else if (int'(log2_bins_ff) > LMAX) begin
         l_eff = dpspm_pkg::LOG2_W'(LMAX);
      end else begin
         l_eff = log2_bins_ff;
      end
   end

   assign n_len   = LW'(1) << l_eff;
   assign n_m1    = n_len - LW'(1);
   assign half_m1 = KW'(n_m1 >> 1);

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   dpspm_pkg::state_type state_ff, state_in;

   logic req_acc;
   logic blk_end;
   logic rd_en;
   logic out_load;

   logic          issue_done_ff, issue_done_in;
   logic [KW-1:0] rd_k_ff, rd_k_in;
   logic          rd_last;

   // Pipeline flags travelling with each bin pair.
   logic          r_valid_ff, a_valid_ff, m_valid_ff, p_valid_ff;
   logic          r_last_ff, a_last_ff, m_last_ff, p_last_ff;

   assign req_acc = req_valid && req_ready;
   // Only the bin at index N-1 closes a block.
   assign blk_end = req_acc && (req_kind == dpspm_pkg::KIND_BIN)
                    && (LW'(req_index) == n_m1);
   assign rd_last = (rd_k_ff == half_m1);

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_sel_ff, rsp_sel_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dpspm_pkg::ST_LOAD: begin
            if (blk_end) begin
               state_in = dpspm_pkg::ST_PASS;
            end
         end
         dpspm_pkg::ST_PASS: begin
            // The last pair has left the power stage and is being accumulated.
            if (p_valid_ff && p_last_ff) begin
               state_in = dpspm_pkg::ST_DRAIN;
            end
         end
         dpspm_pkg::ST_DRAIN: begin
            if (!rsp_valid_ff) begin
               state_in = dpspm_pkg::ST_LOAD;
            end
         end
         default: state_in = dpspm_pkg::ST_LOAD;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         dpspm_pkg::ST_LOAD:  req_ready = 1'b1;
         dpspm_pkg::ST_PASS:  rd_en     = !issue_done_ff;
         dpspm_pkg::ST_DRAIN: out_load  = !rsp_valid_ff;
         default: ;
      endcase
   end

   always_comb begin
      rd_k_in       = rd_k_ff;
      issue_done_in = issue_done_ff;
      if (blk_end) begin
         rd_k_in       = '0;
         issue_done_in = 1'b0;
      end else if (rd_en) begin
         rd_k_in       = rd_k_ff + KW'(1);
         issue_done_in = rd_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dpspm_pkg::ST_LOAD;
         rd_k_ff       <= '0;
         issue_done_ff <= 1'b1;
         r_valid_ff    <= 1'b0;
         a_valid_ff    <= 1'b0;
         m_valid_ff    <= 1'b0;
         p_valid_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_k_ff       <= rd_k_in;
         issue_done_ff <= issue_done_in;
         r_valid_ff    <= rd_en;
         a_valid_ff    <= r_valid_ff;
         m_valid_ff    <= a_valid_ff;
         p_valid_ff    <= m_valid_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stores. Writes happen only while loading; reads only during the pass,
   // so a read never meets a write to the same entry in the same cycle.
   // ------------------------------------------------------------------
   logic [2*SAMPLE_BITS-1:0] bin_mem [MAX_BINS];
   logic [OW-1:0]            mask_mem [HALF];

   logic                     bin_we;
   logic                     mask_we;
   logic [AW-1:0]            wr_slot;
   logic [AW-1:0]            mir_addr;

   assign bin_we   = req_acc && (req_kind == dpspm_pkg::KIND_BIN);
   // Mask writes beyond the positive-frequency half are dropped.
   assign mask_we  = req_acc && (req_kind == dpspm_pkg::KIND_MASK)
                     && (int'(req_index) < HALF);
   assign wr_slot  = AW'(req_index);
   // Mirror bin (N-k) mod N; bin 0 is its own mirror.
   assign mir_addr = AW'((n_len - LW'(rd_k_ff)) & n_m1);

   always_ff @(posedge clock) begin
      if (bin_we) begin
         bin_mem[wr_slot] <= {req_real_part, req_imag_part};
      end
   end

   always_ff @(posedge clock) begin
      if (mask_we) begin
         mask_mem[KW'(req_index)] <= req_mask_level;
      end
   end

   logic [2*SAMPLE_BITS-1:0] bin_k_ff;
   logic [2*SAMPLE_BITS-1:0] bin_m_ff;
   logic [OW-1:0]            mask_r_ff;
   logic [KW-1:0]            k_r_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         bin_k_ff  <= bin_mem[AW'(rd_k_ff)];
         bin_m_ff  <= bin_mem[mir_addr];
         mask_r_ff <= mask_mem[rd_k_ff];
         k_r_ff    <= rd_k_ff;
         r_last_ff <= rd_last;
      end
   end

   // ------------------------------------------------------------------
   // Arithmetic pipeline: split sums, squares, powers.
   // Channel 0 uses re[k]+re[m] and im[k]-im[m]; channel 1 uses
   // im[k]+im[m] and re[k]-re[m].
   // ------------------------------------------------------------------
   logic signed [SAMPLE_BITS-1:0] re_k, im_k, re_m, im_m;
   logic signed [SW1-1:0]         sum_in [2];
   logic signed [SW1-1:0]         dif_in [2];
   logic signed [SW1-1:0]         sum_ff [2];
   logic signed [SW1-1:0]         dif_ff [2];
   logic signed [PW-1:0]          sqa_in [2];
   logic signed [PW-1:0]          sqb_in [2];
   logic signed [PW-1:0]          sqa_ff [2];
   logic signed [PW-1:0]          sqb_ff [2];
   logic [PW-1:0]                 pow_in [2];
   logic [PW-1:0]                 pow_ff [2];
   logic [OW-1:0]                 mask_a_ff, mask_m_ff, mask_p_ff;
   logic [KW-1:0]                 k_a_ff, k_m_ff, k_p_ff;

   assign re_k = bin_k_ff[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign im_k = bin_k_ff[SAMPLE_BITS-1:0];
   assign re_m = bin_m_ff[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign im_m = bin_m_ff[SAMPLE_BITS-1:0];

   assign sum_in[0] = SW1'(re_k) + SW1'(re_m);
   assign dif_in[0] = SW1'(im_k) - SW1'(im_m);
   assign sum_in[1] = SW1'(im_k) + SW1'(im_m);
   assign dif_in[1] = SW1'(re_k) - SW1'(re_m);

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         sqa_in[c] = PW'(sum_ff[c]) * PW'(sum_ff[c]);
         sqb_in[c] = PW'(dif_ff[c]) * PW'(dif_ff[c]);
         // Both squares are at most 2^(2*SAMPLE_BITS), so the sum cannot overflow.
         pow_in[c] = $unsigned(sqa_ff[c]) + $unsigned(sqb_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      dif_ff    <= dif_in;
      sqa_ff    <= sqa_in;
      sqb_ff    <= sqb_in;
      pow_ff    <= pow_in;
      mask_a_ff <= mask_r_ff;
      mask_m_ff <= mask_a_ff;
      mask_p_ff <= mask_m_ff;
      k_a_ff    <= k_r_ff;
      k_m_ff    <= k_a_ff;
      k_p_ff    <= k_m_ff;
      a_last_ff <= r_last_ff;
      m_last_ff <= a_last_ff;
      p_last_ff <= m_last_ff;
   end

   // ------------------------------------------------------------------
   // Peak search and mask check, one bin per cycle for both channels.
   // A later bin only replaces the peak when it is strictly larger, so the
   // lowest bin of a tie is kept.
   // ------------------------------------------------------------------
   acc_type       acc_ff [2];
   acc_type       acc_in [2];
   logic [CW-1:0] pow_cw [2];
   logic [CW-1:0] mask_cw;

   assign mask_cw = CW'(mask_p_ff);

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         pow_cw[c] = CW'(pow_ff[c]);
         acc_in[c] = acc_ff[c];
         if (blk_end) begin
            acc_in[c].found       = 1'b0;
            acc_in[c].best_bin    = '0;
            acc_in[c].best        = CW'(peak_floor_ff);
            acc_in[c].count       = '0;
            acc_in[c].first_bin   = '0;
            acc_in[c].first_power = '0;
            acc_in[c].last_bin    = '0;
            acc_in[c].last_power  = '0;
         end else if (p_valid_ff) begin
            if (pow_cw[c] > acc_ff[c].best) begin
               acc_in[c].found    = 1'b1;
               acc_in[c].best_bin = k_p_ff;
               acc_in[c].best     = pow_cw[c];
            end
            if (mask_enable_ff && (pow_cw[c] > mask_cw)) begin
               if (acc_ff[c].count == '0) begin
                  acc_in[c].first_bin   = k_p_ff;
                  acc_in[c].first_power = pow_cw[c];
               end
               acc_in[c].last_bin   = k_p_ff;
               acc_in[c].last_power = pow_cw[c];
               acc_in[c].count      = acc_ff[c].count + CNTW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // ------------------------------------------------------------------
   // Result buffer: both channel results of a block are loaded together and
   // handed out as two transactions, channel 0 first. Bins and mask entries
   // for the next block are taken while the results wait.
   // ------------------------------------------------------------------
   dpspm_pkg::rsp_type out_ff [2];
   dpspm_pkg::rsp_type out_in [2];
   dpspm_pkg::rsp_type out_cur;

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         out_in[c].channel         = (c == 1);
         out_in[c].peak_found      = acc_ff[c].found;
         out_in[c].peak_bin        = BOW'(acc_ff[c].best_bin);
         out_in[c].peak_power      = OW'(acc_ff[c].best);
         out_in[c].violation_count = COW'(acc_ff[c].count);
         out_in[c].first_bin       = BOW'(acc_ff[c].first_bin);
         out_in[c].first_power     = OW'(acc_ff[c].first_power);
         out_in[c].last_bin        = BOW'(acc_ff[c].last_bin);
         out_in[c].final_power     = OW'(acc_ff[c].last_power);
         out_in[c].last            = (c == 1);
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sel_in   = rsp_sel_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_sel_in   = 1'b0;
      end else if (rsp_valid_ff && rsp_ready) begin
         if (rsp_sel_ff) begin
            rsp_valid_in = 1'b0;
         end else begin
            rsp_sel_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_sel_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rsp_sel_ff   <= rsp_sel_in;
      end
   end

   assign out_cur             = out_ff[rsp_sel_ff];
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_channel         = out_cur.channel;
   assign rsp_peak_found      = out_cur.peak_found;
   assign rsp_peak_bin        = out_cur.peak_bin;
   assign rsp_peak_power      = out_cur.peak_power;
   assign rsp_violation_count = out_cur.violation_count;
   assign rsp_first_bin       = out_cur.first_bin;
   assign rsp_first_power     = out_cur.first_power;
   assign rsp_last_bin        = out_cur.last_bin;
   assign rsp_final_power     = out_cur.final_power;
   assign rsp_last            = out_cur.last;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_first_rsp_is_ch0: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (rsp_channel == 1'b0))
      else $error("result burst did not start with channel 0");

   a_pipe_in_pass: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |-> (state_ff == dpspm_pkg::ST_PASS))
      else $error("power stage active outside the tail pass");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dpspm_pkg::ST_PASS) |->
         ((acc_ff[0].count <= CNTW'(half_m1) + CNTW'(1))
          && (acc_ff[1].count <= CNTW'(half_m1) + CNTW'(1))))
      else $error("violation count exceeds the number of bins");

   a_block_starts_pass: assert property (@(posedge clock) disable iff (reset)
      blk_end |=> ((state_ff == dpspm_pkg::ST_PASS) && !issue_done_ff
                   && (rd_k_ff == '0)))
      else $error("closing bin did not start the tail pass");

endmodule
